FILE: design/dhcpop_pkg.sv
package dhcpop_pkg;

	localparam int MaxAreaBytesDefault = 512;
	localparam int NumFields = 9;

	localparam logic [31:0] MAGIC_COOKIE = 32'h63825363;
	localparam logic [7:0] OPT_PAD = 8'd0;
	localparam logic [7:0] OPT_END = 8'hff;
	localparam logic [7:0] OPT_SUBNET = 8'd1;
	localparam logic [7:0] OPT_TIME_OFFSET = 8'd2;
	localparam logic [7:0] OPT_ROUTER = 8'd3;
	localparam logic [7:0] OPT_DNS = 8'd6;
	localparam logic [7:0] OPT_NTP = 8'd42;
	localparam logic [7:0] OPT_LEASE = 8'd51;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] OPT_SERVER_ID = 8'd54;

	localparam logic [1:0] REG_DNS2 = 2'd0;
	localparam logic [1:0] REG_TIME_OFFSET = 2'd1;
	localparam logic [1:0] REG_NTP = 2'd2;

	typedef enum logic [2:0] {
		PH_MAGIC = 3'd0,
		PH_CODE  = 3'd1,
		PH_LEN   = 3'd2,
		PH_VALUE = 3'd3,
		PH_DONE  = 3'd4,
		PH_SKIP  = 3'd5
	} phase_t;

	// Classified byte handed from the front part to the back part.
	typedef struct packed {
		logic       parse;     // byte falls within the area limit
		logic       last;
		logic [7:0] data;
	} cls_word_t;

	typedef struct packed {
		logic        magic_ok;
		logic [7:0]  msg_kind;
		logic [31:0] subnet_mask;
		logic [31:0] gateway_addr;
		logic [31:0] dns_primary;
		logic [31:0] dns_secondary;
		logic [31:0] ntp_server;
		logic [31:0] lease_seconds;
		logic [31:0] server_ident;
		logic [31:0] clock_offset;
		logic [8:0]  present_bits;
		logic        cut_short;
	} result_t;

endpackage

FILE: design/dhcpop_front.sv
module dhcpop_front import dhcpop_pkg::*; #(
	parameter int MAX_AREA_BYTES = MaxAreaBytesDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [7:0] data_byte,
	input  logic      last_byte,
	output logic      q_valid,
	input  logic      q_ready,
	output cls_word_t q_word
);
	localparam int CW = $clog2(MAX_AREA_BYTES + 1);
	localparam int QD = 2;

	logic [CW-1:0] byte_count_q;
	cls_word_t     fifo_q [QD];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          push, pop;

	assign in_ready = (count_q != 2'(QD));
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (count_q != 2'd0);
	assign q_word = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				if (last_byte) begin
					byte_count_q <= '0;
				end else if (byte_count_q != CW'(MAX_AREA_BYTES)) begin
					byte_count_q <= byte_count_q + 1'b1;
				end
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{parse: (byte_count_q != CW'(MAX_AREA_BYTES)),
				last: last_byte, data: data_byte};
		end
	end

endmodule

FILE: design/dhcpop_back.sv
module dhcpop_back import dhcpop_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      dns2_enable,
	input  logic      time_offset_enable,
	input  logic      ntp_enable,
	input  logic      q_valid,
	output logic      q_ready,
	input  cls_word_t q_word,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   res_q
);
	phase_t      phase_q, phase_d;
	logic [1:0]  magic_index_q;
	logic        magic_good_q;
	logic [7:0]  code_q, remaining_q;
	logic [3:0]  vidx_q;
	logic [31:0] shift_q, shift_nx;
	logic [31:0] field_q [NumFields];
	logic [8:0]  mask_q, store;
	logic        out_valid_q, take, do_byte, good;
	logic [7:0]  b;
	logic [3:0]  vidx_nx;
	logic [7:0]  cookie_byte;

	// Only a last word needs the result register; other words keep flowing.
	assign out_valid = out_valid_q;
	assign q_ready = !out_valid_q || out_ready || !q_word.last;
	assign take = q_valid && q_ready;
	assign do_byte = take && q_word.parse;
	assign b = q_word.data;
	assign vidx_nx = (vidx_q == 4'd15) ? vidx_q : vidx_q + 4'd1;
	assign shift_nx = {shift_q[23:0], b};

	function automatic logic [31:0] sel(input int i);
		logic [31:0] v;
		v = 32'd0;
		if (store[i]) v = shift_nx;
		else if (mask_q[i]) v = field_q[i];
		return v;
	endfunction

	always_comb begin
		case (magic_index_q)
			2'd0: cookie_byte = MAGIC_COOKIE[31:24];
			2'd1: cookie_byte = MAGIC_COOKIE[23:16];
			2'd2: cookie_byte = MAGIC_COOKIE[15:8];
			default: cookie_byte = MAGIC_COOKIE[7:0];
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		store = '0;
		case (phase_q)
			PH_MAGIC: begin
				if (magic_index_q == 2'd3) begin
					phase_d = (magic_good_q && b == cookie_byte) ? PH_CODE : PH_SKIP;
				end
			end
			PH_CODE: begin
				if (b == OPT_END) begin
					phase_d = PH_DONE;
				end else if (b != OPT_PAD) begin
					phase_d = PH_LEN;
				end
			end
			PH_LEN: phase_d = (b == 8'd0) ? PH_CODE : PH_VALUE;
			PH_VALUE: begin
				if (vidx_nx == 4'd1 && code_q == OPT_MSG_TYPE) store[0] = 1'b1;
				if (vidx_nx == 4'd4) begin
					case (code_q)
						OPT_SUBNET: store[1] = 1'b1;
						OPT_ROUTER: store[2] = 1'b1;
						OPT_DNS: store[3] = 1'b1;
						OPT_NTP: store[5] = ntp_enable;
						OPT_LEASE: store[6] = 1'b1;
						OPT_SERVER_ID: store[7] = 1'b1;
						OPT_TIME_OFFSET: store[8] = time_offset_enable;
						default: ;
					endcase
				end
				if (vidx_nx == 4'd8 && code_q == OPT_DNS && dns2_enable) store[4] = 1'b1;
				if (remaining_q == 8'd1) phase_d = PH_CODE;
			end
			default: ;
		endcase
		if (!do_byte) begin
			phase_d = phase_q;
			store = '0;
		end
	end

	assign good = (phase_d != PH_MAGIC) && magic_good_q
		&& !(phase_q == PH_MAGIC && do_byte && b != cookie_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			magic_index_q <= 2'd0;
			magic_good_q <= 1'b1;
			code_q <= 8'd0;
			remaining_q <= 8'd0;
			vidx_q <= 4'd0;
			shift_q <= '0;
			mask_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && q_word.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take && q_word.last) begin
				phase_q <= PH_MAGIC;
				magic_index_q <= 2'd0;
				magic_good_q <= 1'b1;
				mask_q <= '0;
			end else if (do_byte) begin
				phase_q <= phase_d;
				mask_q <= mask_q | store;
				case (phase_q)
					PH_MAGIC: begin
						if (b != cookie_byte) magic_good_q <= 1'b0;
						magic_index_q <= magic_index_q + 2'd1;
					end
					PH_CODE: if (b != OPT_END && b != OPT_PAD) code_q <= b;
					PH_LEN: begin
						remaining_q <= b;
						vidx_q <= 4'd0;
						shift_q <= '0;
					end
					PH_VALUE: begin
						remaining_q <= remaining_q - 8'd1;
						vidx_q <= vidx_nx;
						shift_q <= shift_nx;
					end
					default: ;
				endcase
			end
		end
	end

	// Captured values; the present mask decides whether they are shown.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NumFields; i++) begin
			if (store[i]) field_q[i] <= (i == 0) ? {24'd0, b} : shift_nx;
		end
		if (take && q_word.last) begin
			res_q.magic_ok <= good;
			res_q.msg_kind <= (mask_q[0] || store[0])
				? (store[0] ? b : field_q[0][7:0]) : 8'd0;
			res_q.subnet_mask <= sel(1);
			res_q.gateway_addr <= sel(2);
			res_q.dns_primary <= sel(3);
			res_q.dns_secondary <= sel(4);
			res_q.ntp_server <= sel(5);
			res_q.lease_seconds <= sel(6);
			res_q.server_ident <= sel(7);
			res_q.clock_offset <= sel(8);
			res_q.present_bits <= mask_q | store;
			res_q.cut_short <= !(phase_d == PH_DONE || phase_d == PH_SKIP);
		end
	end

endmodule

FILE: design/dhcp_option_parser_top.sv
// Channel  | Handshake               | Payload
// input    | in_valid / in_ready     | data_byte, last_byte
// output   | out_valid / out_ready   | magic_ok ... cut_short
// config   | cfg_we                  | cfg_index, cfg_data
//
// One word is accepted per cycle while the queue has room; the front part
// registers each word into a two-entry queue and counts bytes against the area
// limit, and the back part runs the option walk on one word per cycle. out_valid
// rises once the result for the word carrying last_byte is registered. Reset
// clears all parse state and sets all three enables. A waiting result holds back
// only the last word of the next packet; the queue holds words meanwhile.
module dhcp_option_parser_top import dhcpop_pkg::*; #(
	parameter int MAX_AREA_BYTES = MaxAreaBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [0:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        magic_ok,
	output logic [7:0]  msg_kind,
	output logic [31:0] subnet_mask,
	output logic [31:0] gateway_addr,
	output logic [31:0] dns_primary,
	output logic [31:0] dns_secondary,
	output logic [31:0] ntp_server,
	output logic [31:0] lease_seconds,
	output logic [31:0] server_ident,
	output logic signed [31:0] clock_offset,
	output logic [8:0]  present_bits,
	output logic        cut_short
);
	logic      dns2_en_q, toff_en_q, ntp_en_q;
	logic      q_valid, q_ready;
	cls_word_t q_word;
	result_t   res;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dns2_en_q <= 1'b1;
			toff_en_q <= 1'b1;
			ntp_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DNS2: dns2_en_q <= cfg_data[0];
				REG_TIME_OFFSET: toff_en_q <= cfg_data[0];
				REG_NTP: ntp_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dhcpop_front #(.MAX_AREA_BYTES(MAX_AREA_BYTES)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .last_byte,
		.q_valid, .q_ready, .q_word
	);

	dhcpop_back u_back (
		.clk, .arst_n,
		.dns2_enable(dns2_en_q), .time_offset_enable(toff_en_q),
		.ntp_enable(ntp_en_q),
		.q_valid, .q_ready, .q_word, .out_valid, .out_ready, .res_q(res)
	);

	assign magic_ok = res.magic_ok;
	assign msg_kind = res.msg_kind;
	assign subnet_mask = res.subnet_mask;
	assign gateway_addr = res.gateway_addr;
	assign dns_primary = res.dns_primary;
	assign dns_secondary = res.dns_secondary;
	assign ntp_server = res.ntp_server;
	assign lease_seconds = res.lease_seconds;
	assign server_ident = res.server_ident;
	assign clock_offset = res.clock_offset;
	assign present_bits = res.present_bits;
	assign cut_short = res.cut_short;

endmodule

FILE: dv/tb_dhcp_option_parser_top.sv
module tb_dhcp_option_parser_top;
	import dhcpop_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The block presents a result once the last word has passed the queue and is taken.
	// The settle wait covers any word still moving through the two-entry queue.
	localparam int SettleCycles = 8;
	localparam int DrainLimit = 200000;
	localparam int ItemTarget = 540;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [0:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        magic_ok;
	logic [7:0]  msg_kind;
	logic [31:0] subnet_mask, gateway_addr, dns_primary, dns_secondary;
	logic [31:0] ntp_server, lease_seconds, server_ident;
	logic signed [31:0] clock_offset;
	logic [8:0]  present_bits;
	logic        cut_short;

	dhcp_option_parser_top DUT (.*);

	always #5 clk = ~clk;

	// Parser mirror: its own copy of the enables and of the per-packet state.
	logic        dns2_on, offset_on, ntp_on;
	phase_t      walk_phase;
	logic [1:0]  cookie_pos;
	logic        cookie_match;
	logic [7:0]  cur_code, bytes_left, value_pos;
	logic [31:0] value_acc;
	int          area_count;
	logic [31:0] field_store [NumFields];
	logic [8:0]  field_seen;

	result_t pending_results [$];
	logic [7:0] packet_bytes [$];

	int  error_count = 0;
	int  words_sent = 0;
	int  packets_sent = 0;
	int  results_checked = 0;
	int  hold_cycles = 0;
	bit  sender_quiet = 0;
	bit  receiver_quiet = 0;

	function automatic void clear_packet();
		walk_phase = PH_MAGIC;
		cookie_pos = '0;
		cookie_match = 1'b1;
		cur_code = '0;
		bytes_left = '0;
		value_pos = '0;
		value_acc = '0;
		area_count = 0;
		foreach (field_store[i]) field_store[i] = '0;
		field_seen = '0;
	endfunction

	function automatic void capture(int slot, logic [31:0] val);
		field_store[slot] = val;
		field_seen[slot] = 1'b1;
	endfunction

	function automatic logic [7:0] cookie_byte(logic [1:0] pos);
		return MAGIC_COOKIE[31 - 8 * pos -: 8];
	endfunction

	// Advances the option walk by one byte and queues a result on the last one.
	function automatic void walk_byte(logic [7:0] b, logic is_last);
		result_t res;
		if (area_count < MaxAreaBytesDefault) begin
			area_count++;
			case (walk_phase)
				PH_MAGIC: begin
					if (b != cookie_byte(cookie_pos)) cookie_match = 1'b0;
					cookie_pos = cookie_pos + 2'd1;
					if (cookie_pos == 2'd0) walk_phase = cookie_match ? PH_CODE : PH_SKIP;
				end
				PH_CODE: begin
					if (b == OPT_END) walk_phase = PH_DONE;
					else if (b != OPT_PAD) begin
						cur_code = b;
						walk_phase = PH_LEN;
					end
				end
				PH_LEN: begin
					bytes_left = b;
					value_pos = '0;
					value_acc = '0;
					walk_phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
				end
				PH_VALUE: begin
					value_pos = value_pos + 8'd1;
					value_acc = {value_acc[23:0], b};
					if (value_pos == 8'd1 && cur_code == OPT_MSG_TYPE) capture(0, {24'd0, b});
					if (value_pos == 8'd4) begin
						case (cur_code)
							OPT_SUBNET:      capture(1, value_acc);
							OPT_ROUTER:      capture(2, value_acc);
							OPT_DNS:         capture(3, value_acc);
							OPT_NTP:         if (ntp_on) capture(5, value_acc);
							OPT_LEASE:       capture(6, value_acc);
							OPT_SERVER_ID:   capture(7, value_acc);
							OPT_TIME_OFFSET: if (offset_on) capture(8, value_acc);
							default: ;
						endcase
					end
					if (value_pos == 8'd8 && cur_code == OPT_DNS && dns2_on) capture(4, value_acc);
					bytes_left = bytes_left - 8'd1;
					if (bytes_left == 8'd0) walk_phase = PH_CODE;
				end
				default: ;
			endcase
		end
		if (is_last) begin
			res.magic_ok = (walk_phase != PH_MAGIC) && cookie_match;
			res.msg_kind = field_store[0][7:0];
			res.subnet_mask = field_store[1];
			res.gateway_addr = field_store[2];
			res.dns_primary = field_store[3];
			res.dns_secondary = field_store[4];
			res.ntp_server = field_store[5];
			res.lease_seconds = field_store[6];
			res.server_ident = field_store[7];
			res.clock_offset = field_store[8];
			res.present_bits = field_seen;
			res.cut_short = !(walk_phase == PH_DONE || walk_phase == PH_SKIP);
			pending_results.push_back(res);
			clear_packet();
		end
	endfunction

	// Sender gaps are mostly short with the occasional long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Offers one word and returns right after the edge that accepted it.
	task automatic send_word(logic [7:0] b, logic is_last);
		int gap;
		gap = sender_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= is_last;
		do @(posedge clk); while (!in_ready);
		walk_byte(b, is_last);
		words_sent++;
	endtask

	task automatic send_packet();
		foreach (packet_bytes[i]) send_word(packet_bytes[i], i == packet_bytes.size() - 1);
		packets_sent++;
		packet_bytes.delete();
	endtask

	// Lowers valid and waits until every expected result is out and the pipe is empty.
	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
			waited++;
			if (waited > DrainLimit) begin
				$display("%0t: timeout waiting for %0d results", $realtime,
					pending_results.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Registers change only with the block idle.
	task automatic write_reg(logic [1:0] idx, logic val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DNS2:        dns2_on = val;
			REG_TIME_OFFSET: offset_on = val;
			REG_NTP:         ntp_on = val;
			default: ;
		endcase
	endtask

	task automatic set_enables(logic dns2, logic toff, logic ntp);
		write_reg(REG_DNS2, dns2);
		write_reg(REG_TIME_OFFSET, toff);
		write_reg(REG_NTP, ntp);
	endtask

	function automatic void put_cookie();
		for (int i = 0; i < 4; i++) packet_bytes.push_back(cookie_byte(i[1:0]));
	endfunction

	// Appends one option; a negative fill means random value bytes, otherwise a fixed value.
	function automatic void put_option(logic [7:0] code, int len, int fill = -1);
		packet_bytes.push_back(code);
		packet_bytes.push_back(len[7:0]);
		for (int i = 0; i < len; i++)
			packet_bytes.push_back(fill < 0 ? 8'($urandom) : fill[7:0]);
	endfunction

	// Builds one packet: mostly well-formed option lists, some malformed ones.
	function automatic void build_random_packet();
		logic [7:0] codes [10];
		int kind, n_opts, len, cut;
		codes = '{OPT_SUBNET, OPT_TIME_OFFSET, OPT_ROUTER, OPT_DNS, OPT_NTP,
			OPT_LEASE, OPT_MSG_TYPE, OPT_SERVER_ID, OPT_DNS, OPT_MSG_TYPE};
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			repeat ($urandom_range(1, 12)) packet_bytes.push_back(8'($urandom));
		end else if (kind == 1) begin
			repeat ($urandom_range(1, 4)) packet_bytes.push_back(8'($urandom));
		end else begin
			put_cookie();
			if (kind == 2) packet_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
			n_opts = $urandom_range(0, 6);
			for (int k = 0; k < n_opts; k++) begin
				if ($urandom_range(0, 7) == 0) packet_bytes.push_back(OPT_PAD);
				case ($urandom_range(0, 9))
					0, 1, 2, 3: len = 4;
					4, 5:       len = 8;
					6:          len = $urandom_range(0, 3);
					default:    len = $urandom_range(0, 12);
				endcase
				put_option($urandom_range(0, 7) == 0 ? 8'($urandom_range(1, 254))
					: codes[$urandom_range(0, 9)], len);
			end
			cut = $urandom_range(0, 9);
			if (cut == 0 && packet_bytes.size() > 1) begin
				repeat ($urandom_range(1, packet_bytes.size() - 1)) void'(packet_bytes.pop_back());
			end else begin
				packet_bytes.push_back(OPT_END);
				if (cut < 3) repeat ($urandom_range(1, 5)) packet_bytes.push_back(8'($urandom));
			end
		end
	endfunction

	// Receiver: random stalls, quiet stretches, and a long hold-off on request.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (receiver_quiet) begin
			out_ready <= 1'b1;
		end else begin
			case ($urandom_range(0, 19))
				0:       out_ready <= 1'b0;
				1, 2, 3: out_ready <= 1'b0;
				default: out_ready <= 1'b1;
			endcase
			if ($urandom_range(0, 199) == 0) hold_cycles <= $urandom_range(10, 40);
		end
	end

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
			error_count++;
		end
	endtask

	// Each accepted result word is checked against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result word with no expectation waiting", $realtime);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				compare_field("magic_ok", want.magic_ok, magic_ok);
				compare_field("msg_kind", want.msg_kind, msg_kind);
				compare_field("subnet_mask", want.subnet_mask, subnet_mask);
				compare_field("gateway_addr", want.gateway_addr, gateway_addr);
				compare_field("dns_primary", want.dns_primary, dns_primary);
				compare_field("dns_secondary", want.dns_secondary, dns_secondary);
				compare_field("ntp_server", want.ntp_server, ntp_server);
				compare_field("lease_seconds", want.lease_seconds, lease_seconds);
				compare_field("server_ident", want.server_ident, server_ident);
				compare_field("clock_offset", want.clock_offset, clock_offset);
				compare_field("present_bits", want.present_bits, present_bits);
				compare_field("cut_short", want.cut_short, cut_short);
			end
		end
	end

	// Hand-built packets covering each capture rule and the malformed cases.
	task automatic test_directed();
		// Smallest valid packet: cookie then end marker.
		put_cookie(); packet_bytes.push_back(OPT_END); send_packet();
		// Every captured option, some with all-ones or all-zeros values, plus padding.
		put_cookie(); packet_bytes.push_back(OPT_PAD);
		put_option(OPT_MSG_TYPE, 1, 8'hff); put_option(OPT_SUBNET, 4, 8'hff);
		put_option(OPT_ROUTER, 4, 0); put_option(OPT_DNS, 8);
		put_option(OPT_NTP, 4); put_option(OPT_LEASE, 4, 8'hff);
		put_option(OPT_SERVER_ID, 4); put_option(OPT_TIME_OFFSET, 4, 8'h80);
		packet_bytes.push_back(OPT_END); send_packet();
		// Short options leave their fields alone, DNS with seven bytes fills only the primary; a zero-length option is legal.
		put_cookie(); put_option(OPT_SUBNET, 2); put_option(OPT_MSG_TYPE, 0);
		put_option(OPT_DNS, 7); put_option(OPT_LEASE, 3);
		packet_bytes.push_back(OPT_END); send_packet();
		// A repeated option overwrites the first capture.
		put_cookie(); put_option(OPT_ROUTER, 4); put_option(OPT_ROUTER, 12);
		packet_bytes.push_back(OPT_END); send_packet();
		// Bad cookie: everything after it is ignored.
		put_cookie(); packet_bytes[3] = 8'h62; put_option(OPT_SUBNET, 4);
		packet_bytes.push_back(OPT_END); send_packet();
		// Packets that end inside the cookie.
		packet_bytes.push_back(cookie_byte(0)); send_packet();
		packet_bytes.push_back(cookie_byte(0)); packet_bytes.push_back(cookie_byte(1));
		packet_bytes.push_back(cookie_byte(2)); send_packet();
		// Bytes after the end marker are ignored.
		put_cookie(); put_option(OPT_LEASE, 4); packet_bytes.push_back(OPT_END);
		put_option(OPT_SUBNET, 4); send_packet();
		// Packet that stops in the middle of an option, and one with no end marker.
		put_cookie(); put_option(OPT_SERVER_ID, 4); void'(packet_bytes.pop_back());
		send_packet();
		put_cookie(); put_option(OPT_DNS, 4); send_packet();
		// Unknown option with a long value between two known ones.
		put_cookie(); put_option(OPT_MSG_TYPE, 1); put_option(8'd254, 20);
		put_option(OPT_SUBNET, 4); packet_bytes.push_back(OPT_END); send_packet();
	endtask

	// Each enable off alone, all off, then all on.
	task automatic test_config();
		logic [2:0] settings [5] = '{3'b011, 3'b101, 3'b110, 3'b000, 3'b111};
		foreach (settings[s]) begin
			set_enables(settings[s][2], settings[s][1], settings[s][0]);
			put_cookie(); put_option(OPT_DNS, 8); put_option(OPT_NTP, 4);
			put_option(OPT_TIME_OFFSET, 4); packet_bytes.push_back(OPT_END);
			send_packet();
		end
	endtask

	// The receiver holds off while the sender keeps offering words back to back.
	task automatic test_backpressure();
		drain();
		@(negedge clk);
		hold_cycles = 120;
		@(posedge clk);
		sender_quiet = 1;
		repeat (8) begin
			put_cookie(); put_option(OPT_MSG_TYPE, 1); packet_bytes.push_back(OPT_END);
			send_packet();
		end
		sender_quiet = 0;
		drain();
	endtask

	task automatic test_random();
		while (words_sent < ItemTarget) begin
			if ($urandom_range(0, 29) == 0) sender_quiet = !sender_quiet;
			if ($urandom_range(0, 29) == 0) receiver_quiet = !receiver_quiet;
			if ($urandom_range(0, 49) == 0)
				set_enables(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			build_random_packet();
			send_packet();
		end
		sender_quiet = 0;
		receiver_quiet = 0;
	endtask

	initial begin
		dns2_on = 1'b1;
		offset_on = 1'b1;
		ntp_on = 1'b1;
		clear_packet();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config();
		test_backpressure();
		test_random();
		drain();
		$display("Covered %0d packets in %0d words, %0d results checked,", packets_sent,
			words_sent, results_checked);
		$display("including malformed packets, enable settings and stalls.");
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("%0t: run did not finish in time", $realtime);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: dhcp_option_parser_top.f
design/dhcpop_pkg.sv
design/dhcpop_front.sv
design/dhcpop_back.sv
design/dhcp_option_parser_top.sv
dv/tb_dhcp_option_parser_top.sv
